// ===== hdl/control_frame_builder_crc8_unit_macros.svh =====
`ifndef CONTROL_FRAME_BUILDER_CRC8_UNIT_MACROS_SVH
`define CONTROL_FRAME_BUILDER_CRC8_UNIT_MACROS_SVH

// same-cycle implication on clk, off while arst_n is low
`define CFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while arst_n is low
`define CFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cfbcrc8_pkg.sv =====
`default_nettype none

package cfbcrc8_pkg;

	localparam int FRAME_LEN = 20;
	localparam int IDX_W     = 5;
	localparam logic [7:0] CRC_POLY = 8'hD5;

	// operation codes carried in tuser
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// register indexes, byte address 4*i
	localparam logic [1:0] REG_HEADER    = 2'd0;
	localparam logic [1:0] REG_FOOTER    = 2'd1;
	localparam logic [1:0] REG_MOTOR_MAP = 2'd2;

	localparam logic [23:0] MOTOR_MAP_RESET = 24'hFAC688;

	// frame byte positions
	localparam logic [IDX_W-1:0] BYTE_HEADER = 5'd0;
	localparam logic [IDX_W-1:0] BYTE_MOTOR0 = 5'd1;
	localparam logic [IDX_W-1:0] BYTE_MOTOR7 = 5'd8;
	localparam logic [IDX_W-1:0] BYTE_FOOT   = 5'd9;
	localparam logic [IDX_W-1:0] BYTE_TOOL   = 5'd10;
	localparam logic [IDX_W-1:0] BYTE_LASER  = 5'd11;
	localparam logic [IDX_W-1:0] BYTE_LED0   = 5'd12;
	localparam logic [IDX_W-1:0] BYTE_LED4   = 5'd16;
	localparam logic [IDX_W-1:0] BYTE_COLOR  = 5'd17;
	localparam logic [IDX_W-1:0] BYTE_CRC    = 5'd18;
	localparam logic [IDX_W-1:0] BYTE_FOOTER = 5'd19;

	// reflected crc-8, lsb of the byte first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] d;
		c = crc;
		d = data;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/control_frame_builder_crc8_unit.sv =====
// control frame builder with crc-8
//
// s_* channel: one beat per item. s_tuser is the operation: event beats queue a
// tool mask/value pair (dropped when the queue is full), tick beats drain the
// queue and send one 20-byte frame on m_*, m_tlast set on the footer byte.
// After a tick beat s_tready stays low while the sequencer reads each queued event
// from the queue memory and then checks it for overlap, stops the drain at an
// event whose mask overlaps the bits already taken, and loads each frame byte
// into the output register; s_tready rises again once the footer byte is loaded.
// The crc covers bytes 1 to 17 and is built one byte per cycle as bytes are
// loaded, while m_tready lets them load, so it is ready for byte 18 without a
// separate step.
// apb port: header at 0x0, footer at 0x4, motor map at 0x8; pready is always 1.
// Reset clears the queue count and pointers, the tool bits, the output valid,
// and returns the registers to their reset values; the queue memory itself is
// not cleared and needs no sweep.
// When m_tready is low the current byte holds in the output register and the
// sequencer waits; a new item is accepted while the footer byte still waits.
`default_nettype none

module control_frame_builder_crc8_unit
	import cfbcrc8_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// apb configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	// input items
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// motor_speeds[63:0], foot_turner[71:64], laser_stepper[79:72],
	// led_levels[119:80], led_color[127:120], tool_value[135:128], tool_mask[143:136]
	input  wire logic [143:0] s_tdata,
	// operation[0]
	input  wire logic [0:0]   s_tuser,
	// frame bytes
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// frame_byte[7:0]
	output logic      [7:0]   m_tdata,
	output logic              m_tlast
);

	`include "control_frame_builder_crc8_unit_macros.svh"

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [7:0]       header_q;
	logic [7:0]       footer_q;
	logic [23:0]      motor_map_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       tool_bits_q;
	logic [7:0]       changed_q;
	logic [7:0]       crc_q;
	logic [IDX_W-1:0] idx_q;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;

	// captured tick payload
	logic [63:0]      motors_q;
	logic [7:0]       foot_q;
	logic [7:0]       laser_q;
	logic [39:0]      leds_q;
	logic [7:0]       color_q;

	logic [15:0]      queue_mem [QUEUE_DEPTH];
	logic [15:0]      rd_q;

	logic             s_accept;
	logic             cfg_write;
	logic             push;
	logic             load;
	logic [7:0]       ev_mask;
	logic [7:0]       ev_value;
	logic [7:0]       motor_byte;
	logic [2:0]       slot;
	logic [IDX_W-1:0] led_idx;
	logic [5:0]       led_off;
	logic [7:0]       byte_sel;

	assign pready    = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_write = psel && penable && pwrite && pready;
	assign push      = s_accept && (s_tuser[0] == OP_EVENT) && (count_q < CNT_FULL);
	assign load      = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign ev_mask   = rd_q[15:8];
	assign ev_value  = rd_q[7:0];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_HEADER:    prdata = {24'd0, header_q};
			REG_FOOTER:    prdata = {24'd0, footer_q};
			REG_MOTOR_MAP: prdata = {8'd0, motor_map_q};
			default:       prdata = 32'd0;
		endcase
	end

	// frame slot to motor byte, later motor wins a collision
	assign slot = 3'(idx_q - BYTE_MOTOR0);
	always_comb begin
		motor_byte = 8'd0;
		for (int i = 0; i < 8; i++) begin
			if (motor_map_q[3*i +: 3] == slot) begin
				motor_byte = motors_q[8*i +: 8];
			end
		end
	end

	assign led_idx = idx_q - BYTE_LED0;
	assign led_off = {led_idx[2:0], 3'b000};

	always_comb begin
		case (idx_q) inside
			BYTE_HEADER:               byte_sel = header_q;
			[BYTE_MOTOR0:BYTE_MOTOR7]: byte_sel = motor_byte;
			BYTE_FOOT:                 byte_sel = foot_q;
			BYTE_TOOL:                 byte_sel = tool_bits_q;
			BYTE_LASER:                byte_sel = laser_q;
			[BYTE_LED0:BYTE_LED4]:     byte_sel = leds_q[led_off +: 8];
			BYTE_COLOR:                byte_sel = color_q;
			BYTE_CRC:                  byte_sel = crc_q;
			BYTE_FOOTER:               byte_sel = footer_q;
			default:                   byte_sel = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_mem[tail_q] <= {s_tdata[143:136], s_tdata[135:128]};
		end
		rd_q <= queue_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (s_accept && (s_tuser[0] == OP_TICK)) begin
			motors_q <= s_tdata[63:0];
			foot_q   <= s_tdata[71:64];
			laser_q  <= s_tdata[79:72];
			leds_q   <= s_tdata[119:80];
			color_q  <= s_tdata[127:120];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			header_q    <= 8'd0;
			footer_q    <= 8'd0;
			motor_map_q <= MOTOR_MAP_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			tool_bits_q <= 8'd0;
			changed_q   <= 8'd0;
			crc_q       <= 8'd0;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= 8'd0;
			m_tlast_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (paddr[3:2])
					REG_HEADER:    header_q    <= pwdata[7:0];
					REG_FOOTER:    footer_q    <= pwdata[7:0];
					REG_MOTOR_MAP: motor_map_q <= pwdata[23:0];
					default:       ;
				endcase
			end

			if (m_tvalid_q && m_tready && !load) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
					if (s_accept && (s_tuser[0] == OP_TICK)) begin
						changed_q <= 8'd0;
						crc_q     <= 8'd0;
						idx_q     <= BYTE_HEADER;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					// rd_q picks up the head entry at this edge
					state_q <= (count_q == '0) ? ST_EMIT : ST_CHECK;
				end
				ST_CHECK: begin
					if ((changed_q & ev_mask) != 8'd0) begin
						state_q <= ST_EMIT;
					end else begin
						changed_q   <= changed_q | ev_mask;
						tool_bits_q <= (tool_bits_q & ~ev_mask) | (ev_value & ev_mask);
						head_q      <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
						count_q     <= count_q - 1'b1;
						state_q     <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= byte_sel;
						m_tlast_q  <= (idx_q == BYTE_FOOTER);
						if ((idx_q >= BYTE_MOTOR0) && (idx_q <= BYTE_COLOR)) begin
							crc_q <= crc8_byte(crc_q, byte_sel);
						end
						if (idx_q == BYTE_FOOTER) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CFB_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL,
		"queue count above depth")
	`CFB_ASSERT_NOW(a_ptr_match, (count_q == '0) || (count_q == CNT_FULL),
		head_q == tail_q, "queue pointers disagree with count")
	`CFB_ASSERT_NOW(a_check_nonempty, state_q == ST_CHECK, count_q != '0,
		"overlap check on an empty queue")
	`CFB_ASSERT_NEXT(a_tool_hold, state_q != ST_CHECK, $stable(tool_bits_q),
		"tool bits changed outside a drain step")

endmodule

`default_nettype wire
